@@ hw/rtl/fall_det_pkg.sv @@
// Shared types and constants for the fall detector: transaction payloads,
// register indexes and reset values. No dependencies.
package fall_det_pkg;

   localparam int ONE_G_COUNTS_DEF = 2048;
   // Signed width for the one-g window compare: holds |axis| and one g plus tolerance
   localparam int NEAR_W = 18;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;
   localparam int IDX_W  = 3;
   localparam int SQ_W   = 31;
   localparam int MAG_W  = 32;

   localparam logic [IDX_W-1:0] REG_OFFSET_X     = 3'd0;
   localparam logic [IDX_W-1:0] REG_OFFSET_Y     = 3'd1;
   localparam logic [IDX_W-1:0] REG_OFFSET_Z     = 3'd2;
   localparam logic [IDX_W-1:0] REG_FALL_THRESH  = 3'd3;
   localparam logic [IDX_W-1:0] REG_IMPACT_THRESH = 3'd4;
   localparam logic [IDX_W-1:0] REG_GRAVITY_TOL  = 3'd5;
   localparam logic [IDX_W-1:0] REG_FALL_WINDOW  = 3'd6;
   localparam logic [IDX_W-1:0] REG_SETTLE       = 3'd7;

   localparam logic signed [15:0] RST_OFFSET_X     = -16'sd372;
   localparam logic signed [15:0] RST_OFFSET_Y     = 16'sd14;
   localparam logic signed [15:0] RST_OFFSET_Z     = 16'sd12;
   localparam logic [15:0]        RST_FALL_THRESH  = 16'd1065;
   localparam logic [15:0]        RST_IMPACT_THRESH = 16'd7496;
   localparam logic [11:0]        RST_GRAVITY_TOL  = 12'd205;
   localparam logic [15:0]        RST_FALL_WINDOW  = 16'd3000;
   localparam logic [15:0]        RST_SETTLE       = 16'd1500;

   localparam logic [MAG_W-1:0] RST_FALL_SQ   = MAG_W'(1065 * 1065);
   localparam logic [MAG_W-1:0] RST_IMPACT_SQ = MAG_W'(7496 * 7496);

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [31:0]        now_ms;
   } fall_det_req_type;

   typedef struct packed {
      logic free_fall_active;
      logic impact_pending;
      logic fall_detected;
   } fall_det_rsp_type;

   // Front-end results handed to the decision stage
   typedef struct packed {
      logic [SQ_W-1:0] x_sq;
      logic [SQ_W-1:0] y_sq;
      logic [SQ_W-1:0] z_sq;
      logic [31:0]     now_ms;
      logic            near_g;
   } fall_det_front_type;

endpackage

@@ hw/rtl/fall_det_front.sv @@
// Front end of the fall detector: offset removal, per-axis squares and the
// one-g rest orientation check. Uses fall_det_pkg.
module fall_det_front #(
   parameter int ONE_G_COUNTS = fall_det_pkg::ONE_G_COUNTS_DEF
) (
   input  fall_det_pkg::fall_det_req_type   sample,
   input  logic signed [15:0]               offset_x,
   input  logic signed [15:0]               offset_y,
   input  logic signed [15:0]               offset_z,
   input  logic [11:0]                      gravity_tol,
   output fall_det_pkg::fall_det_front_type front
);

   localparam int NW = fall_det_pkg::NEAR_W;
   localparam logic signed [NW-1:0] ONE_G = NW'(ONE_G_COUNTS);

   logic signed [15:0] cal_x, cal_y, cal_z;
   logic signed [31:0] prod_x, prod_y, prod_z;
   logic signed [NW-1:0] tol_s, win_hi, win_lo;
   logic signed [NW-1:0] ext_x, ext_z, abs_x, abs_z;
   logic near_x, near_z;

   // Differences wrap to 16 bits
   assign cal_x = sample.accel_x - offset_x;
   assign cal_y = sample.accel_y - offset_y;
   assign cal_z = sample.accel_z - offset_z;

   assign prod_x = cal_x * cal_x;
   assign prod_y = cal_y * cal_y;
   assign prod_z = cal_z * cal_z;

   assign tol_s  = signed'(NW'(gravity_tol));
   assign win_hi = ONE_G + tol_s;
   assign win_lo = ONE_G - tol_s;

   assign ext_x = NW'(cal_x);
   assign ext_z = NW'(cal_z);
   assign abs_x = ext_x[NW-1] ? -ext_x : ext_x;
   assign abs_z = ext_z[NW-1] ? -ext_z : ext_z;

   // Lower bound may go negative: compare signed
   assign near_x = (abs_x <= win_hi) && (abs_x >= win_lo);
   assign near_z = (abs_z <= win_hi) && (abs_z >= win_lo);

   always_comb begin
      front.x_sq   = prod_x[fall_det_pkg::SQ_W-1:0];
      front.y_sq   = prod_y[fall_det_pkg::SQ_W-1:0];
      front.z_sq   = prod_z[fall_det_pkg::SQ_W-1:0];
      front.now_ms = sample.now_ms;
      front.near_g = near_x || near_z;
   end

endmodule

@@ hw/rtl/fall_detector_free_fall_impact_rest.sv @@
// Pipeline: input register, then square stage register, then decision into the
// result register. Accepts one sample per cycle while results are taken;
// rsp_ready low stalls the stages that are full.
// The per-axis squares set the middle stage; the state update closes in the last.
// Reset (synchronous, active high) clears the pipeline and fall state and
// loads every configuration register with its default.
module fall_detector_free_fall_impact_rest #(
   parameter int ONE_G_COUNTS = fall_det_pkg::ONE_G_COUNTS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  fall_det_pkg::fall_det_req_type        req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output fall_det_pkg::fall_det_rsp_type        rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [fall_det_pkg::ADDR_W-1:0]       paddr,
   input  logic [fall_det_pkg::DATA_W-1:0]       pwdata,
   output logic [fall_det_pkg::DATA_W-1:0]       prdata,
   output logic                                  pready
);

   localparam int MW = fall_det_pkg::MAG_W;

   // Configuration registers
   logic signed [15:0] offset_x_ff, offset_y_ff, offset_z_ff;
   logic [15:0] fall_thresh_ff, impact_thresh_ff, fall_window_ff, settle_ff;
   logic [11:0] gravity_tol_ff;
   logic [MW-1:0] fall_sq_ff, impact_sq_ff;
   logic [fall_det_pkg::IDX_W-1:0] reg_idx;
   logic csr_write;

   // Pipeline
   logic s0_valid_ff, s1_valid_ff, out_valid_ff;
   fall_det_pkg::fall_det_req_type s0_data_ff;
   fall_det_pkg::fall_det_front_type s1_data_ff, front;
   fall_det_pkg::fall_det_rsp_type out_data_ff;
   logic out_ready, s1_ready, s0_ready;

   // Fall state
   logic armed_ff, impact_ff, latched_ff;
   logic [31:0] start_time_ff, impact_time_ff;
   logic armed_in, impact_in, latched_in;
   logic [31:0] start_time_in, impact_time_in;
   logic [MW-1:0] mag_sq;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[fall_det_pkg::ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff      <= fall_det_pkg::RST_OFFSET_X;
         offset_y_ff      <= fall_det_pkg::RST_OFFSET_Y;
         offset_z_ff      <= fall_det_pkg::RST_OFFSET_Z;
         fall_thresh_ff   <= fall_det_pkg::RST_FALL_THRESH;
         impact_thresh_ff <= fall_det_pkg::RST_IMPACT_THRESH;
         gravity_tol_ff   <= fall_det_pkg::RST_GRAVITY_TOL;
         fall_window_ff   <= fall_det_pkg::RST_FALL_WINDOW;
         settle_ff        <= fall_det_pkg::RST_SETTLE;
      end else if (csr_write) begin
         case (reg_idx)
            fall_det_pkg::REG_OFFSET_X:      offset_x_ff      <= pwdata[15:0];
            fall_det_pkg::REG_OFFSET_Y:      offset_y_ff      <= pwdata[15:0];
            fall_det_pkg::REG_OFFSET_Z:      offset_z_ff      <= pwdata[15:0];
            fall_det_pkg::REG_FALL_THRESH:   fall_thresh_ff   <= pwdata[15:0];
            fall_det_pkg::REG_IMPACT_THRESH: impact_thresh_ff <= pwdata[15:0];
            fall_det_pkg::REG_GRAVITY_TOL:   gravity_tol_ff   <= pwdata[11:0];
            fall_det_pkg::REG_FALL_WINDOW:   fall_window_ff   <= pwdata[15:0];
            fall_det_pkg::REG_SETTLE:        settle_ff        <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Squared thresholds follow the registers in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         fall_sq_ff   <= fall_det_pkg::RST_FALL_SQ;
         impact_sq_ff <= fall_det_pkg::RST_IMPACT_SQ;
      end else begin
         fall_sq_ff   <= fall_thresh_ff * fall_thresh_ff;
         impact_sq_ff <= impact_thresh_ff * impact_thresh_ff;
      end
   end

   always_comb begin
      case (reg_idx)
         fall_det_pkg::REG_OFFSET_X:      prdata = 32'(unsigned'(offset_x_ff));
         fall_det_pkg::REG_OFFSET_Y:      prdata = 32'(unsigned'(offset_y_ff));
         fall_det_pkg::REG_OFFSET_Z:      prdata = 32'(unsigned'(offset_z_ff));
         fall_det_pkg::REG_FALL_THRESH:   prdata = 32'(fall_thresh_ff);
         fall_det_pkg::REG_IMPACT_THRESH: prdata = 32'(impact_thresh_ff);
         fall_det_pkg::REG_GRAVITY_TOL:   prdata = 32'(gravity_tol_ff);
         fall_det_pkg::REG_FALL_WINDOW:   prdata = 32'(fall_window_ff);
         fall_det_pkg::REG_SETTLE:        prdata = 32'(settle_ff);
         default:                         prdata = '0;
      endcase
   end

   // Each stage advances whenever the next one has room
   assign out_ready = !out_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign s0_ready  = !s0_valid_ff || s1_ready;
   assign req_ready = s0_ready;

   fall_det_front #(
      .ONE_G_COUNTS(ONE_G_COUNTS)
   ) u_front (
      .sample     (s0_data_ff),
      .offset_x   (offset_x_ff),
      .offset_y   (offset_y_ff),
      .offset_z   (offset_z_ff),
      .gravity_tol(gravity_tol_ff),
      .front      (front)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s0_ready)  s0_valid_ff  <= req_valid;
         if (s1_ready)  s1_valid_ff  <= s0_valid_ff;
         if (out_ready) out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req_valid)     s0_data_ff <= req_data;
      if (s1_ready && s0_valid_ff)   s1_data_ff <= front;
      if (out_ready && s1_valid_ff) begin
         out_data_ff.free_fall_active <= armed_in;
         out_data_ff.impact_pending   <= impact_in;
         out_data_ff.fall_detected    <= latched_in;
      end
   end

   assign mag_sq = MW'(s1_data_ff.x_sq) + MW'(s1_data_ff.y_sq) + MW'(s1_data_ff.z_sq);

   // Arm, then impact within the window, then rest after settling
   always_comb begin
      armed_in       = armed_ff;
      impact_in      = impact_ff;
      latched_in     = latched_ff;
      start_time_in  = start_time_ff;
      impact_time_in = impact_time_ff;
      if (mag_sq <= fall_sq_ff && !armed_ff) begin
         armed_in      = 1'b1;
         start_time_in = s1_data_ff.now_ms;
      end
      if (armed_in) begin
         if ((s1_data_ff.now_ms - start_time_in) >= 32'(fall_window_ff)) begin
            armed_in = 1'b0;
         end else if (mag_sq >= impact_sq_ff) begin
            impact_in      = 1'b1;
            impact_time_in = s1_data_ff.now_ms;
            armed_in       = 1'b0;
         end
      end
      if (impact_in && s1_data_ff.near_g &&
          (s1_data_ff.now_ms - impact_time_in) >= 32'(settle_ff)) begin
         impact_in  = 1'b0;
         latched_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         impact_ff      <= 1'b0;
         latched_ff     <= 1'b0;
         start_time_ff  <= '0;
         impact_time_ff <= '0;
      end else if (out_ready && s1_valid_ff) begin
         armed_ff       <= armed_in;
         impact_ff      <= impact_in;
         latched_ff     <= latched_in;
         start_time_ff  <= start_time_in;
         impact_time_ff <= impact_time_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ hw/rtl/fall_det_checker.sv @@
// Port-level checks for the fall detector, bound to the top level.
// Uses fall_det_pkg.
module fall_det_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input fall_det_pkg::fall_det_rsp_type rsp_data,
   input logic                           pready
);

   logic latched_seen_ff;

   // Remember a delivered fall so later transactions can be checked
   always_ff @(posedge clock) begin
      if (reset) begin
         latched_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_data.fall_detected) begin
         latched_seen_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_fall_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && latched_seen_ff |-> rsp_data.fall_detected)
      else $error("fall flag dropped after being reported");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind fall_detector_free_fall_impact_rest fall_det_checker u_fall_det_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data),
   .pready   (pready)
);

@@ test/fall_flag_checker.sv @@
// Fall detector checker: watches the sample, flag and register ports, keeps
// its own copy of the registers and fall state, predicts the flags and compares.
// Depends on fall_det_pkg.
module fall_flag_checker #(
   parameter int ONE_G = fall_det_pkg::ONE_G_COUNTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  fall_det_pkg::fall_det_req_type    req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  fall_det_pkg::fall_det_rsp_type    rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [fall_det_pkg::ADDR_W-1:0]   paddr,
   input  logic [fall_det_pkg::DATA_W-1:0]   pwdata,
   output int                                mismatches,
   output int                                outstanding
);
   import fall_det_pkg::*;

   logic signed [15:0] off_x, off_y, off_z;
   logic [15:0]        fall_thr, impact_thr, window_ms, settle_ms;
   logic [11:0]        grav_tol;

   logic               armed, impact_seen, latched;
   logic [31:0]        fall_start, impact_at;

   fall_det_rsp_type   flags_due[$];
   int                 fail_total = 0;

   assign mismatches = fail_total;

   function automatic logic near_one_g(input logic signed [15:0] a);
      int mag, hi, lo;
      mag = (a < 0) ? -int'(a) : int'(a);
      hi  = ONE_G + int'(grav_tol);
      lo  = ONE_G - int'(grav_tol);
      return (mag <= hi) && (mag >= lo);
   endfunction

   function automatic fall_det_rsp_type update_fall_state(input fall_det_req_type s);
      logic signed [15:0] cx, cy, cz;
      longint             mag_sq, fall_sq, impact_sq;
      logic [31:0]        since;
      fall_det_rsp_type   flags;
      // offset removal wraps to 16 bits
      cx = s.accel_x - off_x;
      cy = s.accel_y - off_y;
      cz = s.accel_z - off_z;
      mag_sq    = longint'(cx) * cx + longint'(cy) * cy + longint'(cz) * cz;
      fall_sq   = longint'(fall_thr) * longint'(fall_thr);
      impact_sq = longint'(impact_thr) * longint'(impact_thr);

      if (mag_sq <= fall_sq && !armed) begin
         armed      = 1'b1;
         fall_start = s.now_ms;
      end
      if (armed) begin
         since = s.now_ms - fall_start;
         if (since >= {16'd0, window_ms}) begin
            armed = 1'b0;
         end else if (mag_sq >= impact_sq) begin
            impact_seen = 1'b1;
            impact_at   = s.now_ms;
            armed       = 1'b0;
         end
      end
      if (impact_seen) begin
         since = s.now_ms - impact_at;
         if (since >= {16'd0, settle_ms} && (near_one_g(cz) || near_one_g(cx))) begin
            impact_seen = 1'b0;
            latched     = 1'b1;
         end
      end
      flags.free_fall_active = armed;
      flags.impact_pending   = impact_seen;
      flags.fall_detected    = latched;
      return flags;
   endfunction

   function automatic void store_register(input logic [IDX_W-1:0] idx,
                                          input logic [DATA_W-1:0] value);
      case (idx)
         REG_OFFSET_X:      off_x      = value[15:0];
         REG_OFFSET_Y:      off_y      = value[15:0];
         REG_OFFSET_Z:      off_z      = value[15:0];
         REG_FALL_THRESH:   fall_thr   = value[15:0];
         REG_IMPACT_THRESH: impact_thr = value[15:0];
         REG_GRAVITY_TOL:   grav_tol   = value[11:0];
         REG_FALL_WINDOW:   window_ms  = value[15:0];
         REG_SETTLE:        settle_ms  = value[15:0];
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      fall_det_rsp_type want;
      if (reset) begin
         off_x       = RST_OFFSET_X;
         off_y       = RST_OFFSET_Y;
         off_z       = RST_OFFSET_Z;
         fall_thr    = RST_FALL_THRESH;
         impact_thr  = RST_IMPACT_THRESH;
         grav_tol    = RST_GRAVITY_TOL;
         window_ms   = RST_FALL_WINDOW;
         settle_ms   = RST_SETTLE;
         armed       = 1'b0;
         impact_seen = 1'b0;
         latched     = 1'b0;
         fall_start  = '0;
         impact_at   = '0;
         flags_due.delete();
      end else begin
         if (psel && penable && pwrite && pready)
            store_register(paddr[IDX_W+1:2], pwdata);
         if (req_valid && req_ready)
            flags_due.push_back(update_fall_state(req_data));
         if (rsp_valid && rsp_ready) begin
            if (flags_due.size() == 0) begin
               $error("flags transaction %b with none expected", rsp_data);
               fail_total++;
            end else begin
               want = flags_due.pop_front();
               if (rsp_data.free_fall_active !== want.free_fall_active) begin
                  $error("free_fall_active: expected %0b, got %0b",
                         want.free_fall_active, rsp_data.free_fall_active);
                  fail_total++;
               end
               if (rsp_data.impact_pending !== want.impact_pending) begin
                  $error("impact_pending: expected %0b, got %0b",
                         want.impact_pending, rsp_data.impact_pending);
                  fail_total++;
               end
               if (rsp_data.fall_detected !== want.fall_detected) begin
                  $error("fall_detected: expected %0b, got %0b",
                         want.fall_detected, rsp_data.fall_detected);
                  fail_total++;
               end
            end
         end
      end
      outstanding <= flags_due.size();
   end

endmodule

@@ test/testbench.sv @@
// Top of the fall detector bench: clock, reset, register writes and sample
// stimulus (directed, then free-fall/impact/rest episodes and noise).
// Depends on fall_det_pkg, fall_flag_checker and the detector itself.
module testbench;
   import fall_det_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ONE_G       = ONE_G_COUNTS_DEF;

   typedef enum int {SAMPLE_REST, SAMPLE_QUIET, SAMPLE_IMPACT, SAMPLE_NOISE} sample_kind_e;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   fall_det_req_type  req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   fall_det_rsp_type  rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [ADDR_W-1:0] paddr     = '0;
   logic [DATA_W-1:0] pwdata    = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   int                mismatches;
   int                outstanding;
   int                idle_pct  = 24;
   int                cycles    = 0;
   int                sent_total = 0;
   logic [31:0]       stamp_ms  = '0;

   // settings currently in the block, used to shape the samples
   logic signed [15:0] cur_off_x = RST_OFFSET_X;
   logic signed [15:0] cur_off_y = RST_OFFSET_Y;
   logic signed [15:0] cur_off_z = RST_OFFSET_Z;
   logic [15:0]        cur_fall_thr   = RST_FALL_THRESH;
   logic [15:0]        cur_impact_thr = RST_IMPACT_THRESH;
   logic [11:0]        cur_tol        = RST_GRAVITY_TOL;
   logic [15:0]        cur_window     = RST_FALL_WINDOW;
   logic [15:0]        cur_settle     = RST_SETTLE;

   fall_detector_free_fall_impact_rest dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   fall_flag_checker #(.ONE_G(ONE_G)) flag_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int clamp16(input int v);
      return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
   endfunction

   function automatic int spread(input int lim);
      return int'($urandom_range(2 * lim)) - lim;
   endfunction

   function automatic int either_sign(input int v);
      return $urandom_range(1) ? v : -v;
   endfunction

   // build a transaction from offset-free values: add the offsets back in
   function automatic fall_det_req_type calibrated(input int ax, input int ay, input int az);
      fall_det_req_type s;
      s.accel_x = 16'(clamp16(ax)) + cur_off_x;
      s.accel_y = 16'(clamp16(ay)) + cur_off_y;
      s.accel_z = 16'(clamp16(az)) + cur_off_z;
      s.now_ms  = stamp_ms;
      return s;
   endfunction

   function automatic fall_det_req_type make_sample(input sample_kind_e kind);
      fall_det_req_type s;
      int lim, level, other, pick;
      case (kind)
         SAMPLE_QUIET: begin
            lim = int'(cur_fall_thr) / 2;
            s = calibrated(spread(lim), spread(lim), spread(lim));
         end
         SAMPLE_IMPACT: begin
            level = either_sign(clamp16(int'(cur_impact_thr) + int'($urandom_range(3000))));
            other = 2000;
            pick  = $urandom_range(2);
            if (pick == 0)
               s = calibrated(level, spread(other), spread(other));
            else if (pick == 1)
               s = calibrated(spread(other), level, spread(other));
            else
               s = calibrated(spread(other), spread(other), level);
         end
         SAMPLE_REST: begin
            level = either_sign(ONE_G + spread(int'(cur_tol) + 64));
            pick  = $urandom_range(9);
            // mostly z carries gravity, sometimes x, rarely y (which never counts)
            if (pick < 6)
               s = calibrated(spread(300), spread(300), level);
            else if (pick < 9)
               s = calibrated(level, spread(300), spread(300));
            else
               s = calibrated(spread(300), level, spread(300));
         end
         default: begin
            s.accel_x = 16'($urandom);
            s.accel_y = 16'($urandom);
            s.accel_z = 16'($urandom);
            s.now_ms  = stamp_ms;
         end
      endcase
      return s;
   endfunction

   task automatic step_time(input int max_ms);
      // now and then jump anywhere, backwards included
      if ($urandom_range(99) < 2)
         stamp_ms = $urandom;
      else
         stamp_ms += $urandom_range(max_ms);
   endtask

   task automatic send_sample(input fall_det_req_type s);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = s;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_total++;
   endtask

   task automatic send_raw(input int ax, input int ay, input int az, input logic [31:0] now);
      fall_det_req_type s;
      stamp_ms  = now;
      s.accel_x = 16'(ax);
      s.accel_y = 16'(ay);
      s.accel_z = 16'(az);
      s.now_ms  = now;
      send_sample(s);
   endtask

   // hold the sender until every flag transaction is back, plus the pipeline depth
   task automatic wait_quiet();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = ADDR_W'({idx, 2'b00});
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_config(input int ox, input int oy, input int oz, input int fall,
                             input int impact, input int tol, input int window,
                             input int settle);
      wait_quiet();
      cur_off_x      = 16'(ox);
      cur_off_y      = 16'(oy);
      cur_off_z      = 16'(oz);
      cur_fall_thr   = 16'(fall);
      cur_impact_thr = 16'(impact);
      cur_tol        = 12'(tol);
      cur_window     = 16'(window);
      cur_settle     = 16'(settle);
      write_reg(REG_OFFSET_X,      DATA_W'(ox));
      write_reg(REG_OFFSET_Y,      DATA_W'(oy));
      write_reg(REG_OFFSET_Z,      DATA_W'(oz));
      write_reg(REG_FALL_THRESH,   DATA_W'(fall));
      write_reg(REG_IMPACT_THRESH, DATA_W'(impact));
      write_reg(REG_GRAVITY_TOL,   DATA_W'(tol));
      write_reg(REG_FALL_WINDOW,   DATA_W'(window));
      write_reg(REG_SETTLE,        DATA_W'(settle));
   endtask

   // rest, free fall, impact (usually inside the window), then rest until settled
   task automatic run_fall_episode();
      int gap_ms;
      repeat ($urandom_range(3)) begin
         step_time(200);
         send_sample(make_sample(SAMPLE_REST));
      end
      repeat (1 + $urandom_range(3)) begin
         step_time(100);
         send_sample(make_sample(SAMPLE_QUIET));
      end
      if ($urandom_range(99) < 80)
         gap_ms = $urandom_range(cur_window);
      else
         gap_ms = int'(cur_window) + int'($urandom_range(500));
      stamp_ms += gap_ms;
      send_sample(make_sample(SAMPLE_IMPACT));
      repeat ($urandom_range(2)) begin
         step_time(50);
         send_sample(make_sample($urandom_range(1) ? SAMPLE_IMPACT : SAMPLE_NOISE));
      end
      repeat (2 + $urandom_range(5)) begin
         stamp_ms += $urandom_range(int'(cur_settle) / 2 + 100);
         send_sample(make_sample(SAMPLE_REST));
      end
   endtask

   task automatic run_random_until(input int target);
      while (sent_total < target) begin
         if ($urandom_range(99) < 85) begin
            run_fall_episode();
         end else begin
            repeat (1 + $urandom_range(3)) begin
               step_time(2000);
               send_sample(make_sample(SAMPLE_NOISE));
            end
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // defaults: a full fall, extremes, wrapped and backwards timestamps
      send_raw(0, 0, 0, 32'd0);
      send_raw(32767, -32768, 32767, 32'd10);
      send_raw(-32768, 32767, -32768, 32'd20);
      send_raw(-372, 14, 2048 + 12, 32'd1600);
      send_raw(-372, 14, 12, 32'd1700);
      send_raw(-372, 14, 12, 32'd100);
      send_raw(-372, 14, 12, 32'hFFFF_FFF0);
      send_raw(20000, 14, 12, 32'h0000_0010);
      send_raw(-2048 - 372, 14, 300, 32'h0000_0010 + 1500);
      send_raw(-32768, -32768, -32768, 32'hFFFF_FFFF);
      send_raw(32767, 32767, 32767, 32'h8000_0000);
      run_random_until(300);
      wait_quiet();
      run_random_until(450);

      // zero fall threshold, tolerance and times, full-scale impact threshold, x and y offsets at the rails
      set_config(-32768, 32767, 0, 0, 65535, 0, 0, 0);
      send_raw(-32768, 32767, 0, 32'd5000);
      send_raw(32767, -32768, 32767, 32'd5000);
      run_random_until(600);

      // everything counts as free fall and impact; long stretch without idling
      idle_pct = 0;
      set_config(32767, -32768, -1, 65535, 0, 2048, 65535, 65535);
      run_random_until(750);
      idle_pct = 24;

      // tolerance beyond one g, zero settle: rest check on the impact sample itself
      set_config(0, 0, 0, 1000, 3000, 4095, 65535, 0);
      send_raw(0, 0, 0, 32'd100);
      send_raw(3000, 0, 2048, 32'd150);
      send_raw(0, 0, 0, 32'd200);
      send_raw(4000, 0, 0, 32'd210);
      run_random_until(850);

      while (sent_total < 1300) begin
         set_config(spread(600), spread(600), spread(600),
                    300 + $urandom_range(2200), 3000 + $urandom_range(17000),
                    $urandom_range(2048), $urandom_range(5000), $urandom_range(3000));
         run_random_until((sent_total + 110 < 1300) ? sent_total + 110 : 1300);
      end

      wait_quiet();
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/fall_det_pkg.sv
hw/rtl/fall_det_front.sv
hw/rtl/fall_detector_free_fall_impact_rest.sv
hw/rtl/fall_det_checker.sv
test/fall_flag_checker.sv
test/testbench.sv
